// ===== hw/rtl/nstep_pkg.sv =====
// Shared types and constants for the Newton step block.
// Used by the pipelined divider and the top level; no dependencies.
`default_nettype none

package nstep_pkg;

   localparam int FRAC_BITS = 9;    // Q9 fraction bits
   localparam int IN_W      = 16;   // Q9 input entries
   localparam int OUT_W     = 6;    // step components
   localparam int DIV_LANES = 9;    // one lane per inverse entry
   localparam int NUM_W     = 17 + FRAC_BITS;  // cofactor (17b) shifted left by the fraction bits
   localparam int DEN_W     = 25;   // determinant after the fraction shift
   localparam int MAG_W     = 25;   // magnitudes of numerator and determinant
   localparam int QUO_W     = 16;   // quotient magnitude bits
   localparam int TAG_W     = 48;   // balanced residual carried through the divider
   localparam int STEP_LIMIT = 25;  // integer clamp of a step component

   localparam logic [QUO_W:0] QUO_POS_LIM = 17'd32767;
   localparam logic [QUO_W:0] QUO_NEG_LIM = 17'd32768;
   localparam logic [QUO_W-1:0] FX_MAX = 16'h7fff;
   localparam logic [QUO_W-1:0] FX_MIN = 16'h8000;

   typedef struct packed {
      logic [DIV_LANES-1:0][NUM_W-1:0] num;
      logic [DEN_W-1:0]                den;
      logic [TAG_W-1:0]                tag;
   } div_req_type;

   typedef struct packed {
      logic [DIV_LANES-1:0][QUO_W-1:0] quo;
      logic [TAG_W-1:0]                tag;
   } div_rsp_type;

   typedef struct packed {
      logic [DIV_LANES-1:0][MAG_W-1:0] rem;
      logic [DIV_LANES-1:0][QUO_W-1:0] quo;
      logic [DIV_LANES-1:0]            neg;
      logic [DIV_LANES-1:0]            ovf;
      logic [MAG_W-1:0]                dmag;
      logic [TAG_W-1:0]                tag;
   } div_work_type;

endpackage

`default_nettype wire

// ===== hw/rtl/nstep_div.sv =====
// Nine-lane pipelined signed divider, one quotient bit per stage, saturating to 16 bits.
// Depends on nstep_pkg.
`default_nettype none

module nstep_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire nstep_pkg::div_req_type in_data,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output nstep_pkg::div_rsp_type    out_data
);

   localparam int QW   = nstep_pkg::QUO_W;
   localparam int MW   = nstep_pkg::MAG_W;
   localparam int NL   = nstep_pkg::DIV_LANES;
   localparam int NSTG = QW + 2;        // prep, one per quotient bit, saturate
   localparam int SW   = MW + QW - 1;   // widest shifted divisor

   logic [NSTG-1:0] v_ff;
   logic [NSTG:0]   en;
   nstep_pkg::div_work_type work_ff [QW+1];
   nstep_pkg::div_work_type prep_in;
   nstep_pkg::div_rsp_type  out_in;
   nstep_pkg::div_rsp_type  out_ff;

   assign en[NSTG] = out_ready;
   for (genvar k = 0; k < NSTG; k++) begin : g_en
      assign en[k] = !v_ff[k] | en[k+1];
   end
   assign in_ready  = en[0];
   assign out_valid = v_ff[NSTG-1];
   assign out_data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) begin
            v_ff[0] <= in_valid;
         end
         for (int k = 1; k < NSTG; k++) begin
            if (en[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   // signs split off, magnitude divide, overflow when quotient needs more than 16 bits
   always_comb begin
      logic              dneg;
      logic              nneg;
      logic [MW-1:0]     dmag;
      logic [MW-1:0]     nmag;
      logic [nstep_pkg::DEN_W-1:0] dn;
      logic [nstep_pkg::NUM_W-1:0] nn;
      dneg = in_data.den[nstep_pkg::DEN_W-1];
      dn   = dneg ? -in_data.den : in_data.den;
      dmag = dn[MW-1:0];
      prep_in      = '0;
      prep_in.dmag = dmag;
      prep_in.tag  = in_data.tag;
      for (int l = 0; l < NL; l++) begin
         nneg = in_data.num[l][nstep_pkg::NUM_W-1];
         nn   = nneg ? -in_data.num[l] : in_data.num[l];
         nmag = nn[MW-1:0];
         prep_in.rem[l] = nmag;
         prep_in.neg[l] = nneg ^ dneg;
         prep_in.ovf[l] = {{QW{1'b0}}, nmag} >= {dmag, {QW{1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         work_ff[0] <= prep_in;
      end
   end

   for (genvar k = 1; k <= QW; k++) begin : g_bit
      localparam int B = QW - k;
      nstep_pkg::div_work_type w_in;

      always_comb begin
         logic [SW-1:0] sh;
         sh   = SW'(work_ff[k-1].dmag) << B;
         w_in = work_ff[k-1];
         for (int l = 0; l < NL; l++) begin
            if (SW'(work_ff[k-1].rem[l]) >= sh) begin
               w_in.rem[l]    = work_ff[k-1].rem[l] - sh[MW-1:0];
               w_in.quo[l][B] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en[k]) begin
            work_ff[k] <= w_in;
         end
      end
   end

   always_comb begin
      logic [QW:0] q;
      out_in.tag = work_ff[QW].tag;
      for (int l = 0; l < NL; l++) begin
         q = {1'b0, work_ff[QW].quo[l]};
         if (work_ff[QW].neg[l]) begin
            if (work_ff[QW].ovf[l] || q > nstep_pkg::QUO_NEG_LIM) begin
               out_in.quo[l] = nstep_pkg::FX_MIN;
            end else begin
               out_in.quo[l] = -work_ff[QW].quo[l];
            end
         end else begin
            if (work_ff[QW].ovf[l] || q > nstep_pkg::QUO_POS_LIM) begin
               out_in.quo[l] = nstep_pkg::FX_MAX;
            end else begin
               out_in.quo[l] = work_ff[QW].quo[l];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[NSTG-1]) begin
         out_ff <= out_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/newton_step_3x3_fixed_top.sv =====
// Top level of the 3x3 Newton step: balancing, cofactors, determinant, inverse, step.
// Depends on nstep_pkg and nstep_div.
`default_nettype none

// One beat in, one beat out; a new matrix is taken every cycle unless req_stall is high.
// From an accepted request to its response: six stages for capture, balancing, cofactor
// products, cofactors, determinant products and determinant, eighteen in the divider
// (sign prep, one quotient bit per stage, saturation), then the residual products and the
// clamped sum in the response register. Every stage holds its own valid bit and advances
// when its successor is free, so bubbles close up under rsp_stall and nothing is dropped.
module newton_step_3x3_fixed_top (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic signed [15:0] req_j_r0c0,
   input  wire logic signed [15:0] req_j_r0c1,
   input  wire logic signed [15:0] req_j_r0c2,
   input  wire logic signed [15:0] req_j_r1c0,
   input  wire logic signed [15:0] req_j_r1c1,
   input  wire logic signed [15:0] req_j_r1c2,
   input  wire logic signed [15:0] req_j_r2c0,
   input  wire logic signed [15:0] req_j_r2c1,
   input  wire logic signed [15:0] req_j_r2c2,
   input  wire logic signed [15:0] req_resid_0,
   input  wire logic signed [15:0] req_resid_1,
   input  wire logic signed [15:0] req_resid_2,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [5:0]       rsp_step_x,
   output logic signed [5:0]       rsp_step_y,
   output logic signed [5:0]       rsp_step_l
);

   localparam int ROW_LIMIT    = 2048;
   localparam int MAX_HALVINGS = 8;
   localparam int STEP_CLAMP   = nstep_pkg::STEP_LIMIT << nstep_pkg::FRAC_BITS;
   // cofactor order: t0 t1 t2 c01 c02 c11 c12 c21 c22
   localparam int PA0 [9] = '{4, 3, 3, 1, 1, 0, 0, 0, 0};
   localparam int PA1 [9] = '{8, 8, 7, 8, 5, 8, 5, 7, 4};
   localparam int PB0 [9] = '{5, 5, 4, 2, 2, 2, 2, 1, 1};
   localparam int PB1 [9] = '{7, 6, 6, 7, 4, 6, 3, 6, 3};
   localparam logic [8:0] COF_NEGATE = 9'b011001000;

   function automatic logic [16:0] mag_f(input logic signed [15:0] v);
      logic signed [16:0] w;
      w = 17'(v);
      return w[16] ? 17'(-w) : 17'(w);
   endfunction

   function automatic logic signed [15:0] cof_f(input logic signed [31:0] p,
                                                input logic signed [31:0] q,
                                                input logic neg);
      logic signed [33:0] d;
      d = 34'(p) - 34'(q);
      if (neg) begin
         d = -d;
      end
      return 16'(d >>> nstep_pkg::FRAC_BITS);
   endfunction

   logic en0, en1, en2, en3, en4, en5, en6, en7;
   logic div_in_ready, div_out_valid;
   nstep_pkg::div_req_type div_req;
   nstep_pkg::div_rsp_type div_rsp;

   logic               v0_ff, v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff;
   logic signed [15:0] j0_ff [9];
   logic signed [15:0] f0_ff [3];
   logic signed [15:0] j1_in [9];
   logic signed [15:0] f1_in [3];
   logic signed [15:0] j1_ff [9];
   logic signed [15:0] f1_ff [3];
   logic signed [31:0] pa2_ff [9];
   logic signed [31:0] pb2_ff [9];
   logic signed [15:0] jr2_ff [3];
   logic signed [15:0] f2_ff [3];
   logic signed [15:0] cf3_ff [9];
   logic signed [15:0] jr3_ff [3];
   logic signed [15:0] f3_ff [3];
   logic signed [31:0] dp4_ff [3];
   logic signed [15:0] cf4_ff [9];
   logic signed [15:0] f4_ff [3];
   logic signed [24:0] det5_in;
   logic signed [24:0] det5_ff;
   logic signed [25:0] num5_in [9];
   logic signed [25:0] num5_ff [9];
   logic signed [15:0] f5_ff [3];
   logic signed [31:0] sp6_ff [9];
   logic signed [5:0]  step7_in [3];
   logic signed [5:0]  step7_ff [3];

   assign en7 = !v7_ff | !rsp_stall;
   assign en6 = !v6_ff | en7;
   assign en5 = !v5_ff | div_in_ready;
   assign en4 = !v4_ff | en5;
   assign en3 = !v3_ff | en4;
   assign en2 = !v2_ff | en3;
   assign en1 = !v1_ff | en2;
   assign en0 = !v0_ff | en1;
   assign req_stall = !en0;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else begin
         if (en0) v0_ff <= req_valid;
         if (en1) v1_ff <= v0_ff;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
         if (en5) v5_ff <= v4_ff;
         if (en6) v6_ff <= div_out_valid;
         if (en7) v7_ff <= v6_ff;
      end
   end

   // stage 0: capture
   always_ff @(posedge clock) begin
      if (en0) begin
         j0_ff <= '{req_j_r0c0, req_j_r0c1, req_j_r0c2,
                    req_j_r1c0, req_j_r1c1, req_j_r1c2,
                    req_j_r2c0, req_j_r2c1, req_j_r2c2};
         f0_ff <= '{req_resid_0, req_resid_1, req_resid_2};
      end
   end

   // stage 1: balance rows 0 and 1; halvings = count of shifts still above the limit
   always_comb begin
      logic [16:0] m;
      logic [3:0]  k;
      j1_in = j0_ff;
      f1_in = f0_ff;
      for (int r = 0; r < 2; r++) begin
         m = mag_f(j0_ff[r*3]);
         if (mag_f(j0_ff[r*3+1]) > m) m = mag_f(j0_ff[r*3+1]);
         if (mag_f(j0_ff[r*3+2]) > m) m = mag_f(j0_ff[r*3+2]);
         k = '0;
         for (int s = 0; s < MAX_HALVINGS; s++) begin
            if ((m >> s) > 17'(ROW_LIMIT)) k = k + 4'd1;
         end
         for (int c = 0; c < 3; c++) begin
            j1_in[r*3+c] = j0_ff[r*3+c] >>> k;
         end
         f1_in[r] = f0_ff[r] >>> k;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         j1_ff <= j1_in;
         f1_ff <= f1_in;
      end
   end

   // stage 2: cofactor products
   always_ff @(posedge clock) begin
      if (en2) begin
         for (int i = 0; i < 9; i++) begin
            pa2_ff[i] <= j1_ff[PA0[i]] * j1_ff[PA1[i]];
            pb2_ff[i] <= j1_ff[PB0[i]] * j1_ff[PB1[i]];
         end
         jr2_ff <= '{j1_ff[0], j1_ff[1], j1_ff[2]};
         f2_ff  <= f1_ff;
      end
   end

   // stage 3: cofactors
   always_ff @(posedge clock) begin
      if (en3) begin
         for (int i = 0; i < 9; i++) begin
            cf3_ff[i] <= cof_f(pa2_ff[i], pb2_ff[i], COF_NEGATE[i]);
         end
         jr3_ff <= jr2_ff;
         f3_ff  <= f2_ff;
      end
   end

   // stage 4: determinant products
   always_ff @(posedge clock) begin
      if (en4) begin
         for (int i = 0; i < 3; i++) begin
            dp4_ff[i] <= jr3_ff[i] * cf3_ff[i];
         end
         cf4_ff <= cf3_ff;
         f4_ff  <= f3_ff;
      end
   end

   // stage 5: determinant (zero low half forced to +-1) and divider numerators
   always_comb begin
      logic signed [33:0] sum;
      logic signed [16:0] n17 [9];
      sum = 34'(dp4_ff[0]) - 34'(dp4_ff[1]) + 34'(dp4_ff[2]);
      det5_in = 25'(sum >>> nstep_pkg::FRAC_BITS);
      if (det5_in[15:0] == '0) begin
         det5_in = det5_in[24] ? -25'sd1 : 25'sd1;
      end
      n17[0] = 17'(cf4_ff[0]);
      n17[1] = 17'(cf4_ff[3]);
      n17[2] = 17'(cf4_ff[4]);
      n17[3] = -17'(cf4_ff[1]);
      n17[4] = 17'(cf4_ff[5]);
      n17[5] = 17'(cf4_ff[6]);
      n17[6] = 17'(cf4_ff[2]);
      n17[7] = 17'(cf4_ff[7]);
      n17[8] = 17'(cf4_ff[8]);
      for (int l = 0; l < 9; l++) begin
         num5_in[l] = 26'(n17[l]) <<< nstep_pkg::FRAC_BITS;
      end
   end

   always_ff @(posedge clock) begin
      if (en5) begin
         det5_ff <= det5_in;
         num5_ff <= num5_in;
         f5_ff   <= f4_ff;
      end
   end

   always_comb begin
      for (int l = 0; l < 9; l++) begin
         div_req.num[l] = num5_ff[l];
      end
      div_req.den = det5_ff;
      div_req.tag = {f5_ff[2], f5_ff[1], f5_ff[0]};
   end

   nstep_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v5_ff),
      .in_ready  (div_in_ready),
      .in_data   (div_req),
      .out_valid (div_out_valid),
      .out_ready (en6),
      .out_data  (div_rsp)
   );

   // stage 6: inverse times balanced residual
   always_ff @(posedge clock) begin
      if (en6) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               sp6_ff[r*3+c] <= $signed(div_rsp.quo[r*3+c]) *
                                $signed(div_rsp.tag[c*16 +: 16]);
            end
         end
      end
   end

   // stage 7: row sums, clamp, drop fraction
   always_comb begin
      logic signed [33:0] d;
      for (int r = 0; r < 3; r++) begin
         d = 34'(sp6_ff[r*3]) + 34'(sp6_ff[r*3+1]) + 34'(sp6_ff[r*3+2]);
         if (d > 34'sd0 + 34'(STEP_CLAMP)) d = 34'(STEP_CLAMP);
         if (d < -34'(STEP_CLAMP)) d = -34'(STEP_CLAMP);
         step7_in[r] = 6'(d >>> nstep_pkg::FRAC_BITS);
      end
   end

   always_ff @(posedge clock) begin
      if (en7) begin
         step7_ff <= step7_in;
      end
   end

   assign rsp_valid  = v7_ff;
   assign rsp_step_x = step7_ff[0];
   assign rsp_step_y = step7_ff[1];
   assign rsp_step_l = step7_ff[2];

   a_det_nonzero: assert property (@(posedge clock) disable iff (reset)
      v5_ff |-> (det5_ff != '0))
      else $error("determinant reached the divider as zero");

   // arithmetic shift of a negative entry can land one below -2048
   a_rows_balanced: assert property (@(posedge clock) disable iff (reset)
      v1_ff |-> (j1_ff[0] >= -2049 && j1_ff[0] <= 2048 &&
                 j1_ff[1] >= -2049 && j1_ff[1] <= 2048 &&
                 j1_ff[2] >= -2049 && j1_ff[2] <= 2048 &&
                 j1_ff[3] >= -2049 && j1_ff[3] <= 2048 &&
                 j1_ff[4] >= -2049 && j1_ff[4] <= 2048 &&
                 j1_ff[5] >= -2049 && j1_ff[5] <= 2048))
      else $error("balanced row entry out of range");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_step_x >= -25 && rsp_step_x <= 25 &&
                     rsp_step_y >= -25 && rsp_step_y <= 25 &&
                     rsp_step_l >= -25 && rsp_step_l <= 25))
      else $error("step component outside clamp");

   a_div_hold: assert property (@(posedge clock) disable iff (reset)
      (div_out_valid && !en6) |=> div_out_valid)
      else $error("divider dropped a stalled beat");

endmodule

`default_nettype wire

// ===== tb/sv/newton_step_3x3_fixed_checker.sv =====
// Scoreboard for the 3x3 Newton step: predicts each step from the accepted request beat
// and compares it with the response beats in order. Standalone; no package needed.
`timescale 1ns / 1ps

module newton_step_3x3_fixed_checker (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               req_stall,
   input  wire logic signed [15:0] req_j_r0c0,
   input  wire logic signed [15:0] req_j_r0c1,
   input  wire logic signed [15:0] req_j_r0c2,
   input  wire logic signed [15:0] req_j_r1c0,
   input  wire logic signed [15:0] req_j_r1c1,
   input  wire logic signed [15:0] req_j_r1c2,
   input  wire logic signed [15:0] req_j_r2c0,
   input  wire logic signed [15:0] req_j_r2c1,
   input  wire logic signed [15:0] req_j_r2c2,
   input  wire logic signed [15:0] req_resid_0,
   input  wire logic signed [15:0] req_resid_1,
   input  wire logic signed [15:0] req_resid_2,
   input  wire logic               rsp_valid,
   input  wire logic               rsp_stall,
   input  wire logic signed [5:0]  rsp_step_x,
   input  wire logic signed [5:0]  rsp_step_y,
   input  wire logic signed [5:0]  rsp_step_l,
   output int                      fail_count,
   output int                      pending_steps
);

   localparam int FRAC = 9;
   localparam longint ROW_LIM = 2048;
   localparam longint CLAMP = 25 * 512;

   typedef struct packed {
      logic signed [5:0] x;
      logic signed [5:0] y;
      logic signed [5:0] l;
   } step_type;

   step_type step_q[$];

   function automatic longint wrap16(longint v);
      logic signed [15:0] w;
      w = v[15:0];
      return longint'(w);
   endfunction

   function automatic longint abs64(longint v);
      return v < 0 ? -v : v;
   endfunction

   // >>> on a signed longint is arithmetic
   function automatic int halvings(longint a, longint b, longint c);
      longint m;
      int k;
      m = abs64(a);
      k = 0;
      if (abs64(b) > m) m = abs64(b);
      if (abs64(c) > m) m = abs64(c);
      while (k < 8 && m > ROW_LIM) begin
         m = m >>> 1;
         k++;
      end
      return k;
   endfunction

   function automatic longint cofactor(longint p, longint q, bit neg);
      longint d;
      d = p - q;
      if (neg) d = -d;
      return wrap16(d >>> FRAC);
   endfunction

   function automatic longint qdiv(longint a, longint b);
      longint r;
      if (b == 0) return a >= 0 ? 32767 : -32768;
      r = (a * 512) / b;
      if (r > 32767) return 32767;
      if (r < -32768) return -32768;
      return r;
   endfunction

   function automatic step_type newton_step(longint j[3][3], longint f[3]);
      longint t0, t1, t2, det;
      longint inv[3][3];
      longint d;
      step_type s;
      int k;
      for (int r = 0; r < 2; r++) begin
         k = halvings(j[r][0], j[r][1], j[r][2]);
         for (int c = 0; c < 3; c++) j[r][c] = j[r][c] >>> k;
         f[r] = f[r] >>> k;
      end
      t0 = cofactor(j[1][1] * j[2][2], j[1][2] * j[2][1], 0);
      t1 = cofactor(j[1][0] * j[2][2], j[1][2] * j[2][0], 0);
      t2 = cofactor(j[1][0] * j[2][1], j[1][1] * j[2][0], 0);
      det = (j[0][0] * t0 - j[0][1] * t1 + j[0][2] * t2) >>> FRAC;
      if (det[15:0] == 16'd0) det = det < 0 ? -1 : 1;
      inv[0][0] = qdiv(t0, det);
      inv[1][0] = qdiv(-t1, det);
      inv[2][0] = qdiv(t2, det);
      inv[0][1] = qdiv(cofactor(j[0][1] * j[2][2], j[0][2] * j[2][1], 1), det);
      inv[0][2] = qdiv(cofactor(j[0][1] * j[1][2], j[0][2] * j[1][1], 0), det);
      inv[1][1] = qdiv(cofactor(j[0][0] * j[2][2], j[0][2] * j[2][0], 0), det);
      inv[1][2] = qdiv(cofactor(j[0][0] * j[1][2], j[0][2] * j[1][0], 1), det);
      inv[2][1] = qdiv(cofactor(j[0][0] * j[2][1], j[0][1] * j[2][0], 1), det);
      inv[2][2] = qdiv(cofactor(j[0][0] * j[1][1], j[0][1] * j[1][0], 0), det);
      for (int r = 0; r < 3; r++) begin
         d = inv[r][0] * f[0] + inv[r][1] * f[1] + inv[r][2] * f[2];
         if (d > CLAMP) d = CLAMP;
         if (d < -CLAMP) d = -CLAMP;
         d = d >>> FRAC;
         if (r == 0) s.x = d[5:0];
         else if (r == 1) s.y = d[5:0];
         else s.l = d[5:0];
      end
      return s;
   endfunction

   always @(posedge clock) begin
      longint j[3][3];
      longint f[3];
      step_type got, want;
      if (reset) begin
         step_q.delete();
         fail_count <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            j[0][0] = req_j_r0c0; j[0][1] = req_j_r0c1; j[0][2] = req_j_r0c2;
            j[1][0] = req_j_r1c0; j[1][1] = req_j_r1c1; j[1][2] = req_j_r1c2;
            j[2][0] = req_j_r2c0; j[2][1] = req_j_r2c1; j[2][2] = req_j_r2c2;
            f[0] = req_resid_0; f[1] = req_resid_1; f[2] = req_resid_2;
            step_q.push_back(newton_step(j, f));
         end
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_step_x, rsp_step_y, rsp_step_l};
            if (step_q.size() == 0) begin
               $display("%0t: unexpected beat, expected none, actual x=%0d y=%0d l=%0d",
                        $time, got.x, got.y, got.l);
               fail_count <= fail_count + 1;
            end else begin
               want = step_q.pop_front();
               if (got != want) begin
                  $display("%0t: step mismatch, expected x=%0d y=%0d l=%0d, actual x=%0d y=%0d l=%0d",
                           $time, want.x, want.y, want.l, got.x, got.y, got.l);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
      pending_steps <= step_q.size();
   end

endmodule

// ===== tb/sv/newton_step_3x3_fixed_top_tb.sv =====
// Top of the Newton step testbench: clock, reset, request stimulus and response stall.
// Depends on newton_step_3x3_fixed_top and newton_step_3x3_fixed_checker.
`timescale 1ns / 1ps

module newton_step_3x3_fixed_top_tb;

   localparam int LATENCY = 26;
   localparam int WATCHDOG = 5000;
   localparam int RANDOM_ITEMS = 800;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic rsp_stall = 1'b0;
   logic signed [15:0] mat [12];
   logic req_stall, rsp_valid;
   logic signed [5:0] rsp_step_x, rsp_step_y, rsp_step_l;
   int fail_count, pending_steps;
   int idle_cycles;
   bit hold_rsp = 1'b0;  // long receiver hold-off
   bit quiet = 1'b0;     // no idling in the last part

   initial for (int i = 0; i < 12; i++) mat[i] = '0;

   always #5 clock = ~clock;

   newton_step_3x3_fixed_top uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_j_r0c0(mat[0]), .req_j_r0c1(mat[1]), .req_j_r0c2(mat[2]),
      .req_j_r1c0(mat[3]), .req_j_r1c1(mat[4]), .req_j_r1c2(mat[5]),
      .req_j_r2c0(mat[6]), .req_j_r2c1(mat[7]), .req_j_r2c2(mat[8]),
      .req_resid_0(mat[9]), .req_resid_1(mat[10]), .req_resid_2(mat[11]),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_step_x(rsp_step_x), .rsp_step_y(rsp_step_y), .rsp_step_l(rsp_step_l)
   );

   newton_step_3x3_fixed_checker chk (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_j_r0c0(mat[0]), .req_j_r0c1(mat[1]), .req_j_r0c2(mat[2]),
      .req_j_r1c0(mat[3]), .req_j_r1c1(mat[4]), .req_j_r1c2(mat[5]),
      .req_j_r2c0(mat[6]), .req_j_r2c1(mat[7]), .req_j_r2c2(mat[8]),
      .req_resid_0(mat[9]), .req_resid_1(mat[10]), .req_resid_2(mat[11]),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_step_x(rsp_step_x), .rsp_step_y(rsp_step_y), .rsp_step_l(rsp_step_l),
      .fail_count(fail_count), .pending_steps(pending_steps)
   );

   // receiver: random stall bursts, or a long hold when asked
   always @(posedge clock) begin
      int burst;
      if (hold_rsp) begin
         rsp_stall <= 1'b1;
      end else if (quiet || reset) begin
         rsp_stall <= 1'b0;
      end else if (burst > 0) begin
         burst--;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 7) == 0) begin
         burst = $urandom_range(1, 10);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
         $display("newton_step_3x3_fixed_top verification failed");
         $finish;
      end
   end

   function automatic logic [15:0] pick_entry(int mode);
      case (mode)
         0: return 16'($urandom);
         1: return 16'($signed($urandom_range(0, 4095)) - 2048);
         2: return 16'($signed($urandom_range(0, 63)) - 32);
         3: return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
         default: return 16'($signed($urandom_range(0, 1023)) - 512);
      endcase
   endfunction

   // hold one beat until accepted; random gap before it unless quiet
   task automatic send_matrix(logic [15:0] v [12]);
      int gap;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 10);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      for (int i = 0; i < 12; i++) mat[i] <= v[i];
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_random(int count);
      logic [15:0] v [12];
      int mode;
      repeat (count) begin
         mode = $urandom_range(0, 5);
         for (int i = 0; i < 12; i++)
            v[i] = pick_entry($urandom_range(0, 3) == 0 ? $urandom_range(0, 4) : mode);
         // sometimes a singular matrix: row 1 copies row 0
         if ($urandom_range(0, 15) == 0) for (int i = 0; i < 3; i++) v[3 + i] = v[i];
         send_matrix(v);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_steps != 0) @(posedge clock);
   endtask

   initial begin
      logic [15:0] v [12];
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: zero, identity, extremes, singular, near-threshold rows
      for (int t = 0; t < 20; t++) begin
         for (int i = 0; i < 12; i++) v[i] = 16'd0;
         case (t)
            0: ;
            1: begin v[0] = 16'd512; v[4] = 16'd512; v[8] = 16'd512;
               v[9] = 16'd512; v[10] = 16'hfe00; v[11] = 16'd256; end
            2: for (int i = 0; i < 12; i++) v[i] = 16'h7fff;
            3: for (int i = 0; i < 12; i++) v[i] = 16'h8000;
            4: for (int i = 0; i < 12; i++) v[i] = (i % 2) ? 16'h8000 : 16'h7fff;
            5: begin v[0] = 16'd2048; v[4] = 16'd2049; v[8] = 16'd512;
               v[9] = 16'h7fff; v[10] = 16'h8000; v[11] = 16'h7fff; end
            6: begin v[0] = 16'h8000; v[4] = 16'hf800; v[8] = 16'h8000;
               v[9] = 16'h8000; v[10] = 16'h7fff; v[11] = 16'h8000; end
            7: begin v[0] = 16'd1; v[4] = 16'd1; v[8] = 16'd1;
               v[9] = 16'h7fff; v[10] = 16'h7fff; v[11] = 16'h7fff; end
            default: for (int i = 0; i < 12; i++) v[i] = pick_entry(t % 5);
         endcase
         send_matrix(v);
      end

      send_random(RANDOM_ITEMS / 3);

      // receiver holds off while requests keep coming
      hold_rsp = 1'b1;
      fork
         send_random(80);
         repeat (200) @(posedge clock);
      join_any
      hold_rsp = 1'b0;
      wait fork;

      // sender pauses until everything is back
      drain();

      send_random(RANDOM_ITEMS / 3);
      quiet = 1'b1;
      send_random(RANDOM_ITEMS / 3);
      drain();
      repeat (LATENCY * 2) @(posedge clock);

      if (fail_count == 0) $display("newton_step_3x3_fixed_top verification clean");
      else $display("newton_step_3x3_fixed_top verification failed");
      $finish;
   end

endmodule
